// ===== sv/positional_sequence_store_unit_defines.svh =====
// assertion macros used by the block that checks itself
`ifndef POSITIONAL_SEQUENCE_STORE_UNIT_DEFINES_SVH
`define POSITIONAL_SEQUENCE_STORE_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define PSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pss assertion failed");

// next-cycle implication, disabled while reset is low
`define PSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pss assertion failed");

`endif

// ===== sv/pss_pkg.sv =====
`default_nettype none

package pss_pkg;

    // field widths
    localparam int OPERATION_W   = 2;
    localparam int POSITION_W    = 6;
    localparam int VALUE_W       = 32;
    localparam int ENTRY_COUNT_W = 7;
    localparam int STATUS_W      = 2;

    // operation codes
    localparam logic [OPERATION_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OPERATION_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OPERATION_W-1:0] OP_ERASE  = 2'd2;
    localparam logic [OPERATION_W-1:0] OP_GET    = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;

    typedef logic signed [VALUE_W-1:0] t_value;

    // input word
    typedef struct packed {
        logic [OPERATION_W-1:0] operation;
        logic [POSITION_W-1:0]  position;
        t_value                 value;
    } t_in_word;

    // output word
    typedef struct packed {
        t_value                   read_value;
        logic [ENTRY_COUNT_W-1:0] entry_count;
        logic [STATUS_W-1:0]      status;
    } t_out_word;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic   step;
        logic   ins_en;
        logic   del_en;
        logic   get_en;
        t_value value;
    } t_cell_cmd;

endpackage

`default_nettype wire

// ===== sv/pss_if.sv =====
`default_nettype none

// input channel
interface pss_in_if import pss_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// output channel
interface pss_out_if import pss_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== sv/pss_cell.sv =====
`default_nettype none

module pss_cell import pss_pkg::*; #(
    parameter int IDX_W = 7,
    parameter int IDX   = 0
) (
    input  wire logic             i_clk,
    input  wire t_cell_cmd        i_cmd,
    input  wire logic [IDX_W-1:0] i_pos,
    input  wire t_value           i_left,
    input  wire t_value           i_right,
    output t_value                o_entry,
    output t_value                o_read
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    t_value r_entry, n_entry;
    t_value r_read, n_read;

    // local hold / load / shift decision
    always_comb begin
        n_entry = r_entry;
        n_read  = r_read;
        if (i_cmd.step) begin
            if (i_cmd.ins_en) begin
                if (MY_IDX == i_pos) begin
                    n_entry = i_cmd.value;
                end else if (MY_IDX > i_pos) begin
                    n_entry = i_left;
                end
            end
            if (i_cmd.del_en && (MY_IDX >= i_pos)) begin
                n_entry = i_right;
            end
            // selected cell drives its word, all others drive zero
            n_read = (i_cmd.get_en && (MY_IDX == i_pos)) ? r_entry : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_read  <= n_read;
    end

    assign o_entry = r_entry;
    assign o_read  = r_read;

endmodule

`default_nettype wire

// ===== sv/positional_sequence_store_unit.sv =====
// Ordered store of up to DEPTH signed 32-bit words with append, insert, erase and get.
// The words live in a row of DEPTH cells; every cell compares its own index with the
// position of the current operation and holds, loads, takes its lower neighbor (insert)
// or takes its upper neighbor (erase), so an insert or erase shifts the whole row at once
// and a new word can be accepted every cycle while the output is not stalled. The
// accepting edge updates the cell row and latches the word a get selects in the cell
// read registers; the output register then loads the OR of the cell read lanes. Back
// pressure on the output stalls both stages; no clearing pass is needed after reset.
`default_nettype none

`include "positional_sequence_store_unit_defines.svh"

module positional_sequence_store_unit import pss_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pss_in_if.sink     i_in,
    pss_out_if.source  o_out
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int POS_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;

    logic             w_accept;
    logic             w_s1_adv;
    logic             w_full;
    logic [POS_W-1:0] w_pos;
    logic [POS_W-1:0] w_cnt;
    logic [POS_W-1:0] w_eff_pos;
    t_cell_cmd        w_cmd;
    t_value           w_entry [DEPTH];
    t_value           w_read [DEPTH];
    t_value           w_read_or;

    logic [CNT_W-1:0]    r_count, n_count;
    logic [STATUS_W-1:0] n_status;
    logic                n_neg1;

    logic                     r_s1_valid;
    logic [STATUS_W-1:0]      r_s1_status;
    logic [ENTRY_COUNT_W-1:0] r_s1_count;
    logic                     r_s1_neg1;

    logic      r_out_valid;
    t_out_word r_out_word;

    // handshake
    assign w_s1_adv    = !r_out_valid || o_out.ready;
    assign i_in.ready  = !r_s1_valid || w_s1_adv;
    assign w_accept    = i_in.valid && i_in.ready;

    assign w_full = (r_count == CNT_W'(DEPTH));
    assign w_pos  = POS_W'(i_in.payload.position);
    assign w_cnt  = POS_W'(r_count);

    // operation decode into a row command
    always_comb begin
        w_cmd        = '0;
        w_cmd.step   = w_accept;
        w_cmd.value  = i_in.payload.value;
        w_eff_pos    = w_pos;
        n_count      = r_count;
        n_status     = ST_OK;
        n_neg1       = 1'b0;
        unique case (i_in.payload.operation)
            OP_APPEND, OP_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    if ((i_in.payload.operation == OP_APPEND) || (w_pos > w_cnt)) begin
                        w_eff_pos = w_cnt;
                    end
                    w_cmd.ins_en = w_accept;
                    n_count      = r_count + 1'b1;
                end
            end
            OP_ERASE: begin
                if (w_pos >= w_cnt) begin
                    n_status = ST_BADPOS;
                end else begin
                    w_cmd.del_en = w_accept;
                    n_count      = r_count - 1'b1;
                end
            end
            OP_GET: begin
                if (w_pos >= w_cnt) begin
                    n_status = ST_BADPOS;
                    n_neg1   = 1'b1;
                end else begin
                    w_cmd.get_en = w_accept;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // row of cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_value w_left, w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_entry[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_entry[g+1];
        end
        pss_cell #(
            .IDX_W (POS_W),
            .IDX   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_pos   (w_eff_pos),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_entry[g]),
            .o_read  (w_read[g])
        );
    end

    // combine read lanes, only the selected cell is nonzero
    always_comb begin
        w_read_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_read_or = w_read_or | w_read[i];
        end
    end

    // count and first stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (i_in.ready) begin
                r_s1_valid <= w_accept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_status <= n_status;
            r_s1_count  <= ENTRY_COUNT_W'(n_count);
            r_s1_neg1   <= n_neg1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && r_s1_valid) begin
            r_out_word.read_value  <= r_s1_neg1 ? t_value'(-1) : w_read_or;
            r_out_word.entry_count <= r_s1_count;
            r_out_word.status      <= r_s1_status;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_word;

    // checks
    `PSS_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))
    `PSS_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, w_cmd.ins_en, r_count == $past(r_count) + 1'b1)
    `PSS_ASSERT_NEXT(a_erase_shrinks, i_clk, i_rst_n, w_cmd.del_en, r_count == $past(r_count) - 1'b1)
    `PSS_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, !i_in.ready, r_s1_valid && r_out_valid)

endmodule

`default_nettype wire
